### rtl/dbpr_pkg.sv
// ============================================================================
// dbpr_pkg: shared types and constants of the desktop bus packet receiver
// Holds the request and result payload structs, the receive phase codes,
// the escape constants and the escape mapping function.
// ============================================================================
package dbpr_pkg;

    // Width of the idle tick counter, the timeout register and the bad count.
    localparam int unsigned CNT_W = 16;

    localparam logic [7:0] ESC_BYTE = 8'hF8;
    localparam logic [7:0] ESC_LO   = 8'hE8;
    localparam logic [7:0] ESC_HI   = 8'hEB;
    localparam logic [7:0] ESC_OFS  = 8'h10;

    localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'h7FFF;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_IDLE = 1'b1;

    localparam logic KIND_BODY  = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    typedef enum logic [2:0] {
        PH_SRC  = 3'b001,
        PH_CODE = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in_req;

    typedef struct packed {
        logic             kind;
        logic [7:0]       body_byte;
        logic [6:0]       byte_index;
        logic [7:0]       source_address;
        logic             last;
        logic [CNT_W-1:0] bad_packets;
    } t_out_req;

    // The byte after an escape maps E8..EB up to F8..FB; others pass through.
    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= ESC_LO && b <= ESC_HI) begin
            r = b + ESC_OFS;
        end
        return r;
    endfunction

endpackage

### rtl/dbpr_deframer.sv
// ============================================================================
// dbpr_deframer: packet framing state and per-request decode
// Updates the framing state for one request and forms its result, if any.
// ============================================================================
module dbpr_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  dbpr_pkg::t_in_req           i_req,
    input  logic [dbpr_pkg::CNT_W-1:0]  i_timeout_limit,
    output logic                        o_res_valid,
    output dbpr_pkg::t_out_req          o_res
);

    dbpr_pkg::t_phase            r_phase,       n_phase;
    logic                        r_escape,      n_escape;
    logic [7:0]                  r_held_source, n_held_source;
    logic [6:0]                  r_body_total,  n_body_total;
    logic [6:0]                  r_body_count,  n_body_count;
    logic [dbpr_pkg::CNT_W-1:0]  r_idle_count,  n_idle_count;
    logic [dbpr_pkg::CNT_W-1:0]  r_bad_count,   n_bad_count;

    logic [dbpr_pkg::CNT_W-1:0]  idle_inc;
    logic                        is_last;

    assign idle_inc = r_idle_count + 1'b1;
    assign is_last  = (r_body_count >= r_body_total);

    always_comb begin
        n_phase       = r_phase;
        n_escape      = r_escape;
        n_held_source = r_held_source;
        n_body_total  = r_body_total;
        n_body_count  = r_body_count;
        n_idle_count  = r_idle_count;
        n_bad_count   = r_bad_count;
        o_res_valid   = 1'b0;
        o_res.kind           = dbpr_pkg::KIND_BODY;
        o_res.body_byte      = i_req.rx_byte;
        o_res.byte_index     = r_body_count;
        o_res.source_address = r_held_source;
        o_res.last           = is_last;
        o_res.bad_packets    = r_bad_count;

        if (i_req.func == dbpr_pkg::FUNC_IDLE) begin
            if (r_phase != dbpr_pkg::PH_SRC) begin
                n_idle_count = idle_inc;
                // A wrapped counter or a reached limit aborts the packet.
                if (idle_inc == '0 || idle_inc >= i_timeout_limit) begin
                    n_bad_count  = r_bad_count + 1'b1;
                    n_phase      = dbpr_pkg::PH_SRC;
                    n_escape     = 1'b0;
                    n_idle_count = '0;
                    n_body_count = '0;
                    o_res_valid  = 1'b1;
                    o_res.kind        = dbpr_pkg::KIND_ABORT;
                    o_res.body_byte   = '0;
                    o_res.byte_index  = '0;
                    o_res.last        = 1'b0;
                    o_res.bad_packets = n_bad_count;
                end
            end
        end else begin
            n_idle_count = '0;
            unique case (r_phase)
                dbpr_pkg::PH_SRC: begin
                    n_held_source = i_req.rx_byte;
                    n_phase       = dbpr_pkg::PH_CODE;
                end
                dbpr_pkg::PH_CODE: begin
                    n_body_total = i_req.rx_byte[6:0];
                    n_body_count = '0;
                    n_escape     = 1'b0;
                    n_phase      = dbpr_pkg::PH_BODY;
                end
                dbpr_pkg::PH_BODY: begin
                    if (!r_escape && i_req.rx_byte == dbpr_pkg::ESC_BYTE) begin
                        n_escape = 1'b1;
                    end else begin
                        if (r_escape) begin
                            o_res.body_byte = dbpr_pkg::unescape(i_req.rx_byte);
                        end
                        n_escape    = 1'b0;
                        o_res_valid = 1'b1;
                        if (is_last) begin
                            n_phase      = dbpr_pkg::PH_SRC;
                            n_body_count = '0;
                        end else begin
                            n_body_count = r_body_count + 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = dbpr_pkg::PH_SRC;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= dbpr_pkg::PH_SRC;
            r_escape      <= 1'b0;
            r_held_source <= '0;
            r_body_total  <= '0;
            r_body_count  <= '0;
            r_idle_count  <= '0;
            r_bad_count   <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_escape      <= n_escape;
            r_held_source <= n_held_source;
            r_body_total  <= n_body_total;
            r_body_count  <= n_body_count;
            r_idle_count  <= n_idle_count;
            r_bad_count   <= n_bad_count;
        end
    end

    a_escape_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_escape |-> r_phase == dbpr_pkg::PH_BODY)
        else $error("escape mark set outside the body phase");

    a_abort_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.kind == dbpr_pkg::KIND_ABORT)
        |=> (r_phase == dbpr_pkg::PH_SRC && !r_escape && r_idle_count == '0))
        else $error("abort did not return to the source address phase");

    a_abort_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.kind == dbpr_pkg::KIND_ABORT)
        |=> r_bad_count == dbpr_pkg::CNT_W'($past(r_bad_count) + 1'b1))
        else $error("bad packet count did not advance on abort");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.last) |=> r_phase == dbpr_pkg::PH_SRC)
        else $error("packet did not end after its last body byte");

endmodule

### rtl/dbpr_out_reg.sv
// ============================================================================
// dbpr_out_reg: result register of the packet receiver
// Holds one result until the downstream side takes it.
// ============================================================================
module dbpr_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  dbpr_pkg::t_out_req  i_data,
    input  logic                i_stall,
    output logic                o_free,
    output logic                o_valid,
    output dbpr_pkg::t_out_req  o_data
);

    logic               r_valid, n_valid;
    dbpr_pkg::t_out_req r_data;

    // The register can take a new result when empty or when emptied this cycle.
    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/desktop_bus_packet_receiver_top.sv
// ============================================================================
// desktop_bus_packet_receiver_top: serial bus packet deframer
// Strips framing and escapes from a byte stream and reports timeouts.
// ============================================================================
// Usage:
// Each input request carries either one received byte or one idle tick. The
// first byte of a packet is the source address, the second a code byte whose
// low seven bits give the body length minus one, and the body bytes follow.
// Each decoded body byte leaves as one result request with its index, the
// source address and a last flag. An escape byte is dropped; a byte E8..EB
// after it maps to F8..FB. Idle ticks inside a packet that reach the timeout
// limit abort the packet and produce one abort result with the bad packet
// count. A request passes from the input register through the deframer
// into the result register. Throughput is one request per cycle while the
// output does not stall, set by this single register to register pass.
// Reset (synchronous, active low) returns to waiting for a source address,
// clears all counters and loads the timeout limit with its default of 32767.
// When the receiver stalls, the result stays in the output register, the
// request in the input register waits, and the input side stalls once both
// are occupied. The timeout register is written over its own channel and
// is always ready; it should be written only while the block is idle.
// ============================================================================
module desktop_bus_packet_receiver_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  dbpr_pkg::t_in_req           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output dbpr_pkg::t_out_req          o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dbpr_pkg::CNT_W-1:0]  i_cfg_data
);

    // Input register: holds one request while it waits for the deframer.
    logic               r_in_valid, n_in_valid;
    dbpr_pkg::t_in_req  r_in_data;
    logic               in_accept;

    // Timeout limit register.
    logic [dbpr_pkg::CNT_W-1:0] r_timeout_limit;

    logic               out_free;
    logic               step;
    logic               res_valid;
    dbpr_pkg::t_out_req res;

    // A request in the input register advances whenever the result register
    // has room, whether or not it produces a result.
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !step;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign n_in_valid = in_accept || (r_in_valid && !step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    // The configuration channel never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= dbpr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout_limit <= i_cfg_data;
        end
    end

    dbpr_deframer u_deframer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_req           (r_in_data),
        .i_timeout_limit (r_timeout_limit),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    dbpr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_data  (res),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule
